/* src/hrl_pkg.sv */
`default_nettype none
package hrl_pkg;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] dir_x;
    logic signed [23:0] dir_y;
    logic [15:0]        step_time;
  } hrl_in_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [23:0] heading_rate;
  } hrl_out_t;

  typedef enum logic [1:0] {
    KIND_TRACK   = 2'd0,
    KIND_HOLD    = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_SPARE   = 2'd3
  } hrl_kind_t;

  typedef enum logic [0:0] {
    REG_MAX_RATE  = 1'b0,
    REG_START_HDG = 1'b1
  } hrl_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_CORDIC,
    ST_ROUND,
    ST_LIMIT_MUL,
    ST_LIMIT_DIV,
    ST_DECIDE,
    ST_RATE_MUL,
    ST_RATE_DIV,
    ST_FINISH,
    ST_OUT
  } hrl_state_t;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int TABLE_LEN = 24;
  localparam logic signed [23:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] RATE_MIN = -24'sh800000;
  localparam logic signed [35:0] PI_Z30 = 36'sd3373259426;
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  // floor(p / 1000000) = (p * LIMIT_RECIP) >> LIMIT_SHIFT for any p below 2^31
  localparam logic [30:0] LIMIT_RECIP = 31'd1125899907;
  localparam int LIMIT_SHIFT = 50;

  function automatic logic signed [35:0] atan_z30(input logic [4:0] i);
    logic signed [35:0] r;
    begin
      r = '0;
      unique case (i)
        5'd0:  r = 36'sh03243F6A8;
        5'd1:  r = 36'sh01DAC6705;
        5'd2:  r = 36'sh00FADBAFC;
        5'd3:  r = 36'sh007F56EA6;
        5'd4:  r = 36'sh003FEAB76;
        5'd5:  r = 36'sh001FFD55B;
        5'd6:  r = 36'sh000FFFAAA;
        5'd7:  r = 36'sh0007FFF55;
        5'd8:  r = 36'sh0003FFFEA;
        5'd9:  r = 36'sh0001FFFFD;
        5'd10: r = 36'sh0000FFFFF;
        5'd11: r = 36'sh00007FFFF;
        5'd12: r = 36'sh00003FFFF;
        5'd13: r = 36'sh00001FFFF;
        5'd14: r = 36'sh00000FFFF;
        5'd15: r = 36'sh000007FFF;
        5'd16: r = 36'sh000003FFF;
        5'd17: r = 36'sh000001FFF;
        5'd18: r = 36'sh000000FFF;
        5'd19: r = 36'sh0000007FF;
        5'd20: r = 36'sh0000003FF;
        5'd21: r = 36'sh0000001FF;
        5'd22: r = 36'sh0000000FF;
        5'd23: r = 36'sh00000007F;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* src/heading_rate_limiter.sv */
`default_nettype none
// heading_rate_limiter: a track item with a long vector passes the length test, the cordic
// rotations, rounding, the limit multiply and divide, the decision, the rate multiply and
// divide, then finish and output; a short vector skips the cordic and a limited turn skips
// the rate multiply and divide; other kinds go straight to output. One item in flight.
// synchronous active-low reset: max_turn_rate 25736, start_heading 0, stored heading
// and rate zero, sequencer idle, no result pending
module heading_rate_limiter #(
  parameter int ATAN_ITERATIONS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hrl_pkg::hrl_in_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hrl_pkg::hrl_out_t    out_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_data
);
  import hrl_pkg::*;

  localparam int ZSH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [17:0] PI_FX =
    18'(((64'd31415926 << ANGLE_FRAC_BITS) + 64'd5000000) / 64'd10000000);
  localparam logic signed [35:0] ZROUND = 36'sd1 <<< (ZSH - 1);

  // state and registers
  hrl_state_t         st_r, st_nxt;
  logic [14:0]        max_rate_r;
  logic signed [17:0] last_hdg_r, last_hdg_nxt;
  logic signed [23:0] last_rate_r, last_rate_nxt;
  hrl_in_t            item_r;
  logic [15:0]        dt_r;
  logic signed [17:0] target_r, target_nxt;
  logic signed [17:0] hdg_r, hdg_nxt;
  logic signed [23:0] rate_r, rate_nxt;
  logic [47:0]        mul_r;         // product register before divide
  logic [47:0]        mul_nxt;
  logic [18:0]        dmag;
  logic [61:0]        lim_prod_r;    // rate times dt, scaled by the reciprocal of 1e6
  logic [17:0]        m_r;           // limit in angle units
  logic               direct_r, direct_nxt;
  logic               neg_r, neg_nxt;
  logic signed [18:0] d_r, d_nxt;
  hrl_out_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // length test
  logic [47:0] sq_x, sq_y;
  logic [55:0] len_sum;
  logic        len_ok;

  // cordic and divider units
  logic        cor_start, cor_done;
  logic signed [35:0] cor_z;
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic signed [35:0] zr;
  logic signed [17:0] zc;

  hrl_cordic #(.ITERS(ATAN_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start),
    .x_in(item_r.dir_x), .y_in(item_r.dir_y), .done(cor_done), .z_out(cor_z)
  );

  // divides the rounded rate numerator by the step time
  hrl_div #(.NUM_W(48), .DEN_W(16)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(dt_r),
    .done(div_done), .quo(div_quo)
  );

  assign sq_x    = 48'($signed(item_r.dir_x) * $signed(item_r.dir_x));
  assign sq_y    = 48'($signed(item_r.dir_y) * $signed(item_r.dir_y));
  assign len_sum = 56'(sq_x) + 56'(sq_y);

  always_comb begin
    zr = (cor_z + ZROUND) >>> ZSH;
    if (zr > 36'(PI_FX))       zc = PI_FX;
    else if (zr < -36'(PI_FX)) zc = -PI_FX;
    else                       zc = zr[17:0];
  end

  assign in_stall = (st_r != ST_IDLE) || out_valid_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:      if (in_valid && !in_stall) st_nxt = ST_LEN;
      ST_LEN: begin
        if (item_r.kind != KIND_TRACK) st_nxt = ST_OUT;
        else if (len_ok)              st_nxt = ST_CORDIC;
        else                          st_nxt = ST_LIMIT_MUL;
      end
      ST_CORDIC:    if (cor_done) st_nxt = ST_ROUND;
      ST_ROUND:     st_nxt = ST_LIMIT_MUL;
      ST_LIMIT_MUL: st_nxt = ST_LIMIT_DIV;
      ST_LIMIT_DIV: st_nxt = ST_DECIDE;
      ST_DECIDE:    st_nxt = direct_nxt ? ST_RATE_MUL : ST_FINISH;
      ST_RATE_MUL:  st_nxt = ST_RATE_DIV;
      ST_RATE_DIV:  if (div_done) st_nxt = ST_FINISH;
      ST_FINISH:    st_nxt = ST_OUT;
      ST_OUT:       st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  logic signed [18:0] m_s, two_pi, lm, lp, ch;
  logic [47:0] qr;
  always_comb begin
    target_nxt = target_r; hdg_nxt = hdg_r; rate_nxt = rate_r;
    direct_nxt = direct_r; neg_nxt = neg_r; d_nxt = d_r;
    last_hdg_nxt = last_hdg_r; last_rate_nxt = last_rate_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r;
    cor_start = 1'b0; div_start = 1'b0; div_num = mul_r;
    len_ok = (len_sum * 56'd100) > (56'd1 << 24);
    m_s = $signed({1'b0, m_r});
    two_pi = 19'(PI_FX) <<< 1;
    lm = 19'(last_hdg_r) - m_s;
    if (lm < -19'(PI_FX)) lm = lm + two_pi;
    lp = 19'(last_hdg_r) + m_s;
    if (lp > 19'(PI_FX)) lp = lp - two_pi;
    ch = '0;
    qr = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (st_r)
      ST_LEN: begin
        if (item_r.kind == KIND_TRACK) begin
          if (len_ok) cor_start = 1'b1;
          else        target_nxt = last_hdg_r;
        end
      end
      ST_ROUND:     target_nxt = zc;
      ST_DECIDE: begin
        direct_nxt = 1'b0;
        d_nxt = 19'(target_r) - 19'(last_hdg_r);
        if (d_nxt > 19'(PI_FX)) begin
          hdg_nxt = (d_nxt - two_pi < -m_s) ? lm[17:0] : target_r;
          rate_nxt = -24'($signed({1'b0, max_rate_r}));
        end else if (d_nxt < -19'(PI_FX)) begin
          hdg_nxt = (d_nxt + two_pi > m_s) ? lp[17:0] : target_r;
          rate_nxt = 24'($signed({1'b0, max_rate_r}));
        end else if (d_nxt < -m_s) begin
          hdg_nxt = lm[17:0];
          rate_nxt = -24'($signed({1'b0, max_rate_r}));
        end else if (d_nxt > m_s) begin
          hdg_nxt = lp[17:0];
          rate_nxt = 24'($signed({1'b0, max_rate_r}));
        end else begin
          hdg_nxt = target_r;
          direct_nxt = 1'b1;
        end
        if (hdg_nxt > PI_FX) hdg_nxt = PI_FX;
        else if (hdg_nxt < -PI_FX) hdg_nxt = -PI_FX;
        neg_nxt = d_nxt < 0;
      end
      ST_RATE_MUL: begin
        // divider takes the numerator straight from the product
        div_start = 1'b1;
        div_num = mul_nxt;
      end
      ST_RATE_DIV: begin
        if (div_done) begin
          // rounded quotient magnitude, then sign and saturate
          qr = div_quo;
          if (qr > 48'(RATE_MAX) + 48'd1) rate_nxt = neg_r ? RATE_MIN : RATE_MAX;
          else if (neg_r) rate_nxt = 24'(-$signed(49'(qr)));
          else if (qr > 48'(RATE_MAX)) rate_nxt = RATE_MAX;
          else rate_nxt = qr[23:0];
        end
      end
      ST_FINISH: begin
        ch = 19'(hdg_r) - 19'(last_hdg_r);
        if (ch < 0) ch = -ch;
        if (ch <= m_s) hdg_nxt = 18'((19'(last_hdg_r) + 19'(hdg_r)) >>> 1);
        rate_nxt = 24'((25'(last_rate_r) + 25'(rate_r)) >>> 1);
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        priority if (item_r.kind == KIND_TRACK) begin
          out_nxt.heading = 16'(hdg_r);
          out_nxt.heading_rate = rate_r;
          last_hdg_nxt = hdg_r;
          last_rate_nxt = rate_r;
        end else if (item_r.kind == KIND_HOLD) begin
          out_nxt.heading = 16'(last_hdg_r);
          out_nxt.heading_rate = '0;
        end else begin
          out_nxt.heading = '0;
          out_nxt.heading_rate = '0;
          last_hdg_nxt = '0;
        end
      end
      default: ;
    endcase
    // start heading write reloads the stored heading, clamped to +-pi
    if (cfg_we && cfg_index == REG_START_HDG) begin
      if ($signed(cfg_data) > PI_FX)       last_hdg_nxt = PI_FX;
      else if ($signed(cfg_data) < -PI_FX) last_hdg_nxt = -PI_FX;
      else                                 last_hdg_nxt = 18'($signed(cfg_data));
    end
  end

  // product register feeding the limit multiply and the divider
  always_comb begin
    mul_nxt = mul_r;
    dmag = d_r < 0 ? -d_r : d_r;
    if (st_r == ST_LEN)
      mul_nxt = 48'(max_rate_r) * 48'(dt_r);
    else if (st_r == ST_DECIDE)
      mul_nxt = '0;
    else if (st_r == ST_RATE_MUL)
      mul_nxt = 48'(dmag) * 48'(USEC_PER_SEC) + 48'(dt_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      max_rate_r  <= 15'd25736;
      last_hdg_r  <= '0;
      last_rate_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      last_hdg_r  <= last_hdg_nxt;
      last_rate_r <= last_rate_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_MAX_RATE) max_rate_r <= cfg_data[14:0];
    end
    if (st_r == ST_IDLE && in_valid && !in_stall) begin
      item_r <= in_data;
      dt_r   <= (in_data.step_time == '0) ? 16'd1 : in_data.step_time;
    end
    // limit = floor(rate * dt / 1e6) by reciprocal multiply, product below 2^31
    if (st_r == ST_LIMIT_MUL) lim_prod_r <= 62'(mul_r[30:0]) * 62'(LIMIT_RECIP);
    if (st_r == ST_LIMIT_DIV) m_r <= {6'd0, lim_prod_r[61:LIMIT_SHIFT]};
    mul_r    <= (st_r == ST_DECIDE) ? mul_r : mul_nxt;
    target_r <= target_nxt;
    hdg_r    <= hdg_nxt;
    rate_r   <= rate_nxt;
    direct_r <= direct_nxt;
    neg_r    <= neg_nxt;
    d_r      <= d_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only appears once the sequencer has run an item
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == ST_OUT) else $error("result without item");
  // no new item while a result is pending
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item accepted with result pending");
  // stored heading never leaves +-pi
  a_hdg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (last_hdg_r <= PI_FX) && (last_hdg_r >= -PI_FX)) else $error("heading out of range");
endmodule
`default_nettype wire

/* src/hrl_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle
module hrl_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

/* src/hrl_cordic.sv */
`default_nettype none
// vectoring cordic, one rotation per cycle, angle accumulator in 30 frac bits
module hrl_cordic #(
  parameter int ITERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [23:0] x_in,
  input  wire logic signed [23:0] y_in,
  output logic                    done,
  output logic signed [35:0]      z_out
);
  import hrl_pkg::*;

  localparam int CNT_W = 5;

  logic signed [34:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [34:0] xs, ys, x0, y0;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    x0 = {{3{x_in[23]}}, x_in, 8'd0};
    y0 = {{3{y_in[23]}}, y_in, 8'd0};
    if (start) begin
      // left half plane: rotate by pi first
      if (x_in < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = (y_in >= 0) ? PI_Z30 : -PI_Z30;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_z30(i_r);
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_z30(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == CNT_W'(ITERS - 1) || i_r == CNT_W'(TABLE_LEN - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

  assign done  = done_r;
  assign z_out = z_r;
endmodule
`default_nettype wire

/* tb/sv/heading_rate_limiter_test.sv */
`default_nettype none
module heading_rate_limiter_test;
  import hrl_pkg::*;

  localparam int FRAC = 13;
  localparam int ITERS = 16;
  localparam longint PI_A = 25736;
  localparam longint PI_Z = 64'sd3373259426;
  localparam int SETTLE = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hrl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hrl_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  heading_rate_limiter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: our own copy of registers and stored heading and rate
  longint turn_limit;
  longint held_heading;
  longint held_rate;
  hrl_out_t pending_cmds[$];
  int error_count = 0;
  bit gaps_on = 1'b1;
  int idle_cycles = 0;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, xs, ys;
    longint tbl [16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      z = (y >= 0) ? PI_Z : -PI_Z;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += tbl[i];
      end else begin
        x -= ys; y += xs; z -= tbl[i];
      end
    end
    z = shr(z + ((64'sd1 << (30 - FRAC)) >> 1), 30 - FRAC);
    return lim(z, -PI_A, PI_A);
  endfunction

  // next heading command for one tick; updates the stored heading and rate
  function automatic hrl_out_t next_command(hrl_in_t it);
    hrl_out_t r;
    longint dx, dy, dt, hdg, rate, m, len2, target, d, mag, ch;
    bit direct;
    dx = longint'(it.dir_x);
    dy = longint'(it.dir_y);
    dt = it.step_time == 0 ? 1 : longint'(it.step_time);
    hdg = 0;
    rate = 0;
    direct = 1'b0;
    if (it.kind == KIND_TRACK) begin
      m = (turn_limit * dt) / 1000000;
      len2 = dx * dx + dy * dy;
      target = (len2 * 100 > (64'sd1 << 24)) ? angle_of(dy, dx) : held_heading;
      d = target - held_heading;
      if (d > PI_A) begin
        // wrap going negative
        if (d - 2 * PI_A < -m) begin
          hdg = held_heading - m;
          if (hdg < -PI_A) hdg += 2 * PI_A;
        end else hdg = target;
        rate = -turn_limit;
      end else if (d < -PI_A) begin
        if (d + 2 * PI_A > m) begin
          hdg = held_heading + m;
          if (hdg > PI_A) hdg -= 2 * PI_A;
        end else hdg = target;
        rate = turn_limit;
      end else if (d < -m) begin
        hdg = held_heading - m;
        if (hdg < -PI_A) hdg += 2 * PI_A;
        rate = -turn_limit;
      end else if (d > m) begin
        hdg = held_heading + m;
        if (hdg > PI_A) hdg -= 2 * PI_A;
        rate = turn_limit;
      end else begin
        hdg = target;
        direct = 1'b1;
      end
      hdg = lim(hdg, -PI_A, PI_A);
      if (direct) begin
        mag = (d < 0 ? -d : d) * 1000000;
        mag = (mag + dt / 2) / dt;
        rate = d < 0 ? -mag : mag;
      end
      rate = lim(rate, -8388608, 8388607);
      ch = hdg - held_heading;
      if (ch < 0) ch = -ch;
      if (ch <= m) hdg = shr(held_heading + hdg, 1);
      rate = shr(held_rate + rate, 1);
      held_heading = hdg;
      held_rate = rate;
    end else if (it.kind == KIND_HOLD) begin
      hdg = held_heading;
    end else begin
      // invalid time and the spare code clear the heading only
      held_heading = 0;
    end
    r.heading = hdg[15:0];
    r.heading_rate = rate[23:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input hrl_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_RATE) turn_limit = longint'(val[14:0]);
    else held_heading = lim(longint'($signed(val)), -PI_A, PI_A);
  endtask

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_item(input hrl_in_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds = {pending_cmds, next_command(it)};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic hrl_in_t track_item(longint x, longint y, int dt);
    hrl_in_t it;
    it.kind = KIND_TRACK;
    it.dir_x = x[23:0];
    it.dir_y = y[23:0];
    it.step_time = dt[15:0];
    return it;
  endfunction

  function automatic hrl_in_t random_item();
    hrl_in_t it;
    int sel;
    it = track_item($signed(24'($urandom())), $signed(24'($urandom())),
                    $urandom_range(0, 65535));
    sel = $urandom_range(0, 19);
    if (sel == 0) it.kind = KIND_HOLD;
    else if (sel == 1) it.kind = KIND_INVALID;
    else if (sel == 2) it.kind = KIND_SPARE;
    else if (sel < 6) begin
      // short vectors, near or under the length threshold
      it.dir_x = 24'(int'($urandom_range(0, 900)) - 450);
      it.dir_y = 24'(int'($urandom_range(0, 900)) - 450);
    end
    if (sel > 12) it.step_time = 16'($urandom_range(0, 20000));
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    hrl_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_data.heading !== want.heading)
          report_mismatch("heading", out_data.heading, want.heading);
        if (out_data.heading_rate !== want.heading_rate)
          report_mismatch("heading_rate", out_data.heading_rate, want.heading_rate);
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    int burst;
    if (gaps_on && !out_stall && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 10);
      out_stall <= 1'b1;
      fork
        begin
          repeat (burst) @(posedge clk);
          out_stall <= 1'b0;
        end
      join_none
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed;
    send_item(track_item(8388607, 0, 1000));
    send_item(track_item(-8388608, 0, 65535));
    send_item(track_item(0, 8388607, 0));
    send_item(track_item(0, -8388608, 65535));
    send_item(track_item(-8388608, -8388608, 50000));
    send_item(track_item(-4096, 1, 65535));
    send_item(track_item(-4096, -1, 65535));
    send_item(track_item(0, 0, 10000));
    send_item(track_item(409, 0, 10000));
    send_item(track_item(410, 0, 10000));
    send_item(track_item(4096, 4096, 1));
    begin
      hrl_in_t it;
      it = track_item(4096, 0, 0);
      it.kind = KIND_HOLD;
      send_item(it);
      it.kind = KIND_INVALID;
      send_item(it);
      it.kind = KIND_SPARE;
      send_item(it);
    end
    send_item(track_item(-4096, 100, 65535));
  endtask

  task automatic test_registers;
    write_reg(REG_MAX_RATE, 16'd32767);
    write_reg(REG_START_HDG, 16'(25736));
    send_item(track_item(-4096, -10, 65535));
    send_item(track_item(4096, 0, 65535));
    drain();
    write_reg(REG_MAX_RATE, 16'd0);
    write_reg(REG_START_HDG, 16'hFFFF);
    send_item(track_item(4096, 4096, 65535));
    send_item(track_item(-4096, -4096, 100));
    drain();
    write_reg(REG_START_HDG, 16'h8000);
    write_reg(REG_MAX_RATE, 16'd1);
    send_item(track_item(4096, 0, 65535));
    drain();
    write_reg(REG_START_HDG, 16'h7FFF);
    write_reg(REG_MAX_RATE, 16'h7FFF);
    send_item(track_item(-4096, 5, 30000));
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAX_RATE, 16'($urandom_range(0, 32767)));
      write_reg(REG_START_HDG, 16'($urandom_range(0, 51472)) - 16'd25736);
      if (ph == 5) gaps_on = 1'b0;
      for (int n = 0; n < 150; n++) send_item(random_item());
      drain();
    end
  endtask

  initial begin
    turn_limit = 25736;
    held_heading = 0;
    held_rate = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_registers();
    test_random();
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
src/hrl_pkg.sv
src/hrl_div.sv
src/hrl_cordic.sv
src/heading_rate_limiter.sv
tb/sv/heading_rate_limiter_test.sv
